// ===== hdl/vbps_pkg.sv =====
package vbps_pkg;

   // default sizes
   localparam int DEF_MAX_STATE      = 8;
   localparam int DEF_MAX_LAG        = 4;
   localparam int DEF_RESIDUAL_DEPTH = 1024;
   localparam int DEF_FRAC_BITS      = 16;

   // field widths fixed by the interface
   localparam int FUNC_W  = 3;
   localparam int LAGF_W  = 2;
   localparam int ROWF_W  = 10;
   localparam int VARF_W  = 3;
   localparam int VALUE_W = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   // function codes
   localparam logic [FUNC_W-1:0] FUNC_LOAD_COEF  = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_LOAD_ICPT  = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_LOAD_RESID = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_LOAD_START = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_RESTART    = 3'd4;
   localparam logic [FUNC_W-1:0] FUNC_STEP       = 3'd5;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_STATE_COUNT    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LAG_COUNT      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RESIDUAL_COUNT = 2'd2;

   // commands from controller to datapath
   typedef struct packed {
      logic wr_coef;
      logic wr_icpt;
      logic wr_resid;
      logic wr_start;
      logic restart;
      logic step_start;
      logic issue;
      logic first;
      logic last;
      logic shift;
      logic emit_load;
      logic emit_last;
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic out_free;
   } status_type;

endpackage

// ===== hdl/vbps_ctrl.sv =====
module vbps_ctrl #(
   parameter int MAX_STATE      = vbps_pkg::DEF_MAX_STATE,
   parameter int MAX_LAG        = vbps_pkg::DEF_MAX_LAG,
   parameter int RESIDUAL_DEPTH = vbps_pkg::DEF_RESIDUAL_DEPTH,
   parameter int SW = (MAX_STATE > 1) ? $clog2(MAX_STATE) : 1,
   parameter int LW = (MAX_LAG > 1) ? $clog2(MAX_LAG) : 1,
   parameter int RW = (RESIDUAL_DEPTH > 1) ? $clog2(RESIDUAL_DEPTH) : 1
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [vbps_pkg::FUNC_W-1:0]         req_func,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [vbps_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [vbps_pkg::CSR_DATA_W-1:0]     csr_data,
   input  vbps_pkg::status_type                status,
   output vbps_pkg::cmd_type                   cmd,
   output logic [SW-1:0]                       j_idx,
   output logic [LW-1:0]                       l_idx,
   output logic [SW-1:0]                       i_idx,
   output logic [SW-1:0]                       nm1,
   output logic [LW-1:0]                       nlm1,
   output logic [RW-1:0]                       nrm1
);
   import vbps_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_MAC   = 3'd1;
   localparam logic [2:0] ST_DRAIN = 3'd2;
   localparam logic [2:0] ST_SHIFT = 3'd3;
   localparam logic [2:0] ST_EMIT  = 3'd4;

   logic [2:0]    state_ff, state_in;
   logic [3:0]    sc_ff, sc_in;
   logic [2:0]    lc_ff, lc_in;
   logic [10:0]   rc_ff, rc_in;
   logic [SW-1:0] j_ff, j_in, i_ff, i_in;
   logic [LW-1:0] l_ff, l_in;
   logic [1:0]    drain_ff, drain_in;
   logic          accept;
   logic [31:0]   sc_w, lc_w, rc_w, nm1_w, nlm1_w, nrm1_w;

   // clamped counts
   always_comb begin
      sc_w = 32'(sc_ff);
      lc_w = 32'(lc_ff);
      rc_w = 32'(rc_ff);
      if (sc_w == 32'd0) nm1_w = 32'd0;
      else if (sc_w > 32'(MAX_STATE)) nm1_w = 32'(MAX_STATE - 1);
      else nm1_w = sc_w - 32'd1;
      if (lc_w == 32'd0) nlm1_w = 32'd0;
      else if (lc_w > 32'(MAX_LAG)) nlm1_w = 32'(MAX_LAG - 1);
      else nlm1_w = lc_w - 32'd1;
      if (rc_w == 32'd0) nrm1_w = 32'd0;
      else if (rc_w > 32'(RESIDUAL_DEPTH)) nrm1_w = 32'(RESIDUAL_DEPTH - 1);
      else nrm1_w = rc_w - 32'd1;
   end

   assign nm1  = nm1_w[SW-1:0];
   assign nlm1 = nlm1_w[LW-1:0];
   assign nrm1 = nrm1_w[RW-1:0];

   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign accept    = req_valid && !req_stall;
   assign j_idx     = j_ff;
   assign l_idx     = l_ff;
   assign i_idx     = i_ff;

   // configuration registers
   always_comb begin
      sc_in = sc_ff;
      lc_in = lc_ff;
      rc_in = rc_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_STATE_COUNT:    sc_in = csr_data[3:0];
            CSR_LAG_COUNT:      lc_in = csr_data[2:0];
            CSR_RESIDUAL_COUNT: rc_in = csr_data[10:0];
            default: ;
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      j_in     = j_ff;
      l_in     = l_ff;
      i_in     = i_ff;
      drain_in = drain_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.wr_coef  = (req_func == FUNC_LOAD_COEF);
               cmd.wr_icpt  = (req_func == FUNC_LOAD_ICPT);
               cmd.wr_resid = (req_func == FUNC_LOAD_RESID);
               cmd.wr_start = (req_func == FUNC_LOAD_START);
               cmd.restart  = (req_func == FUNC_RESTART);
               if (req_func == FUNC_STEP) begin
                  cmd.step_start = 1'b1;
                  j_in     = '0;
                  l_in     = '0;
                  i_in     = '0;
                  state_in = ST_MAC;
               end
            end
         end
         ST_MAC: begin
            cmd.issue = 1'b1;
            cmd.first = (l_ff == '0) && (i_ff == '0);
            cmd.last  = (l_ff == nlm1) && (i_ff == nm1);
            if (i_ff != nm1) begin
               i_in = i_ff + 1'b1;
            end else begin
               i_in = '0;
               if (l_ff != nlm1) begin
                  l_in = l_ff + 1'b1;
               end else begin
                  l_in = '0;
                  if (j_ff != nm1) begin
                     j_in = j_ff + 1'b1;
                  end else begin
                     drain_in = 2'd2;
                     state_in = ST_DRAIN;
                  end
               end
            end
         end
         ST_DRAIN: begin
            if (drain_ff == 2'd0) state_in = ST_SHIFT;
            else drain_in = drain_ff - 2'd1;
         end
         ST_SHIFT: begin
            cmd.shift = 1'b1;
            j_in      = '0;
            state_in  = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit_load = 1'b1;
               cmd.emit_last = (j_ff == nm1);
               if (j_ff == nm1) state_in = ST_IDLE;
               else j_in = j_ff + 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         sc_ff    <= 4'd1;
         lc_ff    <= 3'd1;
         rc_ff    <= 11'd1;
         drain_ff <= '0;
         j_ff     <= '0;
         l_ff     <= '0;
         i_ff     <= '0;
      end else begin
         state_ff <= state_in;
         sc_ff    <= sc_in;
         lc_ff    <= lc_in;
         rc_ff    <= rc_in;
         drain_ff <= drain_in;
         j_ff     <= j_in;
         l_ff     <= l_in;
         i_ff     <= i_in;
      end
   end

endmodule

// ===== hdl/vbps_datapath.sv =====
module vbps_datapath #(
   parameter int MAX_STATE      = vbps_pkg::DEF_MAX_STATE,
   parameter int MAX_LAG        = vbps_pkg::DEF_MAX_LAG,
   parameter int RESIDUAL_DEPTH = vbps_pkg::DEF_RESIDUAL_DEPTH,
   parameter int FRAC_BITS      = vbps_pkg::DEF_FRAC_BITS,
   parameter int SW = (MAX_STATE > 1) ? $clog2(MAX_STATE) : 1,
   parameter int LW = (MAX_LAG > 1) ? $clog2(MAX_LAG) : 1,
   parameter int RW = (RESIDUAL_DEPTH > 1) ? $clog2(RESIDUAL_DEPTH) : 1
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [vbps_pkg::LAGF_W-1:0]         req_lag_index,
   input  logic [vbps_pkg::ROWF_W-1:0]         req_row_index,
   input  logic [vbps_pkg::VARF_W-1:0]         req_from_var,
   input  logic [vbps_pkg::VARF_W-1:0]         req_to_var,
   input  logic signed [vbps_pkg::VALUE_W-1:0] req_load_value,
   input  logic                                rsp_stall,
   output logic                                rsp_valid,
   output logic [vbps_pkg::VARF_W-1:0]         rsp_var_index,
   output logic signed [vbps_pkg::VALUE_W-1:0] rsp_next_value,
   output logic                                rsp_last,
   input  vbps_pkg::cmd_type                   cmd,
   output vbps_pkg::status_type                status,
   input  logic [SW-1:0]                       j_idx,
   input  logic [LW-1:0]                       l_idx,
   input  logic [SW-1:0]                       i_idx,
   input  logic [SW-1:0]                       nm1,
   input  logic [LW-1:0]                       nlm1,
   input  logic [RW-1:0]                       nrm1
);
   import vbps_pkg::*;

   localparam int COEF_DEPTH  = 1 << (LW + 2 * SW);
   localparam int RESID_DEPTH = RESIDUAL_DEPTH << SW;
   localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);
   localparam logic signed [63:0] SAT_HI = 64'sh0000_0000_7FFF_FFFF;
   localparam logic signed [63:0] SAT_LO = -64'sh0000_0000_8000_0000;

   // tables
   logic signed [31:0] coef_mem  [COEF_DEPTH];
   logic signed [31:0] resid_mem [RESID_DEPTH];
   logic signed [31:0] icpt_ff   [MAX_STATE];
   logic signed [31:0] start_ff  [MAX_LAG][MAX_STATE];
   logic signed [31:0] lag_ff    [MAX_LAG][MAX_STATE];
   logic signed [31:0] next_ff   [MAX_STATE];

   logic [31:0]   lag_w, row_w, from_w, to_w, nrm1_w, emit_w;
   logic          lag_ok, row_ok, from_ok, to_ok;
   logic [RW-1:0] row_ff;

   // pipeline registers
   logic signed [31:0] coef_rd_ff, lagv_rd_ff, icpt_rd_ff, resid_rd_ff;
   logic signed [63:0] prod_ff, base_ff, acc_ff, rounded, acc_in;
   logic          v1_ff, first1_ff, last1_ff, v2_ff, first2_ff, last2_ff;
   logic [SW-1:0] j1_ff, j2_ff;

   // output register
   logic               rsp_valid_ff;
   logic [VARF_W-1:0]  rsp_var_ff;
   logic signed [31:0] rsp_value_ff;
   logic               rsp_last_ff;

   // load index checks
   always_comb begin
      lag_w   = 32'(req_lag_index);
      row_w   = 32'(req_row_index);
      from_w  = 32'(req_from_var);
      to_w    = 32'(req_to_var);
      nrm1_w  = 32'(nrm1);
      emit_w  = 32'(j_idx);
      lag_ok  = lag_w < 32'(MAX_LAG);
      row_ok  = row_w < 32'(RESIDUAL_DEPTH);
      from_ok = from_w < 32'(MAX_STATE);
      to_ok   = to_w < 32'(MAX_STATE);
   end

   // coefficient memory
   always_ff @(posedge clock) begin
      if (cmd.wr_coef && lag_ok && from_ok && to_ok)
         coef_mem[{lag_w[LW-1:0], to_w[SW-1:0], from_w[SW-1:0]}] <= req_load_value;
      coef_rd_ff <= coef_mem[{l_idx, j_idx, i_idx}];
   end

   // residual memory
   always_ff @(posedge clock) begin
      if (cmd.wr_resid && row_ok && to_ok)
         resid_mem[{row_w[RW-1:0], to_w[SW-1:0]}] <= req_load_value;
      if (cmd.issue && cmd.first)
         resid_rd_ff <= resid_mem[{row_ff, j_idx}];
   end

   // shock row, clamped below the residual count
   always_ff @(posedge clock) begin
      if (cmd.step_start) begin
         if (row_w > nrm1_w) row_ff <= nrm1;
         else row_ff <= row_w[RW-1:0];
      end
   end

   // intercepts, start lags and lag store
   always_ff @(posedge clock) begin
      if (cmd.wr_icpt && to_ok) icpt_ff[to_w[SW-1:0]] <= req_load_value;
      if (cmd.wr_start && lag_ok && to_ok)
         start_ff[lag_w[LW-1:0]][to_w[SW-1:0]] <= req_load_value;
      if (cmd.restart) begin
         lag_ff <= start_ff;
      end else if (cmd.shift) begin
         for (int l = 0; l < MAX_LAG; l++) begin
            for (int j = 0; j < MAX_STATE; j++) begin
               if (32'(j) <= 32'(nm1)) begin
                  if (l == 0) lag_ff[l][j] <= next_ff[j];
                  else if (32'(l) <= 32'(nlm1)) lag_ff[l][j] <= lag_ff[(l > 0) ? l - 1 : 0][j];
               end
            end
         end
      end
      if (cmd.issue) lagv_rd_ff <= lag_ff[l_idx][i_idx];
      if (cmd.issue && cmd.first) icpt_rd_ff <= icpt_ff[j_idx];
   end

   // multiply stage and base sum
   always_ff @(posedge clock) begin
      prod_ff <= 64'(coef_rd_ff) * 64'(lagv_rd_ff);
      base_ff <= 64'(icpt_rd_ff) + 64'(resid_rd_ff);
      j1_ff   <= j_idx;
      j2_ff   <= j1_ff;
   end

   // round, accumulate and saturate
   always_comb begin
      rounded = (prod_ff + HALF) >>> FRAC_BITS;
      acc_in  = (first2_ff ? base_ff : acc_ff) + rounded;
   end

   always_ff @(posedge clock) begin
      if (v2_ff) begin
         acc_ff <= acc_in;
         if (last2_ff) begin
            if (acc_in > SAT_HI) next_ff[j2_ff] <= 32'sh7FFF_FFFF;
            else if (acc_in < SAT_LO) next_ff[j2_ff] <= 32'sh8000_0000;
            else next_ff[j2_ff] <= acc_in[31:0];
         end
      end
   end

   // stage valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff     <= 1'b0;
         v2_ff     <= 1'b0;
         first1_ff <= 1'b0;
         first2_ff <= 1'b0;
         last1_ff  <= 1'b0;
         last2_ff  <= 1'b0;
      end else begin
         v1_ff     <= cmd.issue;
         v2_ff     <= v1_ff;
         first1_ff <= cmd.first;
         first2_ff <= first1_ff;
         last1_ff  <= cmd.last;
         last2_ff  <= last1_ff;
      end
   end

   // result word register
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.emit_load) begin
         rsp_var_ff   <= emit_w[VARF_W-1:0];
         rsp_value_ff <= next_ff[j_idx];
         rsp_last_ff  <= cmd.emit_last;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_var_index  = rsp_var_ff;
   assign rsp_next_value = rsp_value_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

// ===== hdl/var_bootstrap_path_stepper_unit.sv =====
// Vector autoregression path stepper, Q16.16 values.
// Input channel req_*: one word per item; func selects a table load (coefficient,
// intercept, residual row column, start lag), a restart that copies the start
// lags into the lag store, or a step that takes req_row_index as the shock row.
// Loads and restart give no result.
// A step runs one shared multiply-accumulate over state_count * state_count *
// lag_count products, one per cycle, then drains a three-stage pipe, shifts the
// lag store and sends state_count result words on rsp_*, last set on the final.
// Words then follow one per cycle while the output is not stalled; req_stall
// is high from the step until its final word sits in the output register.
// Configuration words go in on csr_* (index 0 state count, 1 lag count,
// 2 residual count); csr_ready is always high; write only while idle.
// Reset sets all counts to one and empties the output; the tables are undefined
// until loaded. A stalled result word holds until taken, and the sequencer waits.
module var_bootstrap_path_stepper_unit #(
   parameter int MAX_STATE      = vbps_pkg::DEF_MAX_STATE,
   parameter int MAX_LAG        = vbps_pkg::DEF_MAX_LAG,
   parameter int RESIDUAL_DEPTH = vbps_pkg::DEF_RESIDUAL_DEPTH,
   parameter int FRAC_BITS      = vbps_pkg::DEF_FRAC_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [vbps_pkg::FUNC_W-1:0]         req_func,
   input  logic [vbps_pkg::LAGF_W-1:0]         req_lag_index,
   input  logic [vbps_pkg::ROWF_W-1:0]         req_row_index,
   input  logic [vbps_pkg::VARF_W-1:0]         req_from_var,
   input  logic [vbps_pkg::VARF_W-1:0]         req_to_var,
   input  logic signed [vbps_pkg::VALUE_W-1:0] req_load_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [vbps_pkg::VARF_W-1:0]         rsp_var_index,
   output logic signed [vbps_pkg::VALUE_W-1:0] rsp_next_value,
   output logic                                rsp_last,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [vbps_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [vbps_pkg::CSR_DATA_W-1:0]     csr_data
);
   import vbps_pkg::*;

   localparam int SW = (MAX_STATE > 1) ? $clog2(MAX_STATE) : 1;
   localparam int LW = (MAX_LAG > 1) ? $clog2(MAX_LAG) : 1;
   localparam int RW = (RESIDUAL_DEPTH > 1) ? $clog2(RESIDUAL_DEPTH) : 1;

   cmd_type       cmd;
   status_type    status;
   logic [SW-1:0] j_idx, i_idx, nm1;
   logic [LW-1:0] l_idx, nlm1;
   logic [RW-1:0] nrm1;

   // sequencer
   vbps_ctrl #(
      .MAX_STATE(MAX_STATE), .MAX_LAG(MAX_LAG), .RESIDUAL_DEPTH(RESIDUAL_DEPTH),
      .SW(SW), .LW(LW), .RW(RW)
   ) u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_func(req_func),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data),
      .status(status), .cmd(cmd),
      .j_idx(j_idx), .l_idx(l_idx), .i_idx(i_idx),
      .nm1(nm1), .nlm1(nlm1), .nrm1(nrm1)
   );

   // tables, multiply-accumulate and output register
   vbps_datapath #(
      .MAX_STATE(MAX_STATE), .MAX_LAG(MAX_LAG), .RESIDUAL_DEPTH(RESIDUAL_DEPTH),
      .FRAC_BITS(FRAC_BITS), .SW(SW), .LW(LW), .RW(RW)
   ) u_datapath (
      .clock(clock), .reset(reset),
      .req_lag_index(req_lag_index), .req_row_index(req_row_index),
      .req_from_var(req_from_var), .req_to_var(req_to_var),
      .req_load_value(req_load_value),
      .rsp_stall(rsp_stall), .rsp_valid(rsp_valid),
      .rsp_var_index(rsp_var_index), .rsp_next_value(rsp_next_value),
      .rsp_last(rsp_last),
      .cmd(cmd), .status(status),
      .j_idx(j_idx), .l_idx(l_idx), .i_idx(i_idx),
      .nm1(nm1), .nlm1(nlm1), .nrm1(nrm1)
   );

endmodule
